// ===== src/msq_pkg.sv =====
// Shared types, constants and table functions for the marching squares segment block.
// No dependencies; every other file imports this package.
package msq_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int CFG_DIM_W   = 11;
  localparam int LIM_W       = (COL_W + 1 > CFG_DIM_W) ? COL_W + 1 : CFG_DIM_W;
  localparam int SP_W        = 6;
  localparam int COORD_W     = 16;
  localparam int CASE_W      = 4;
  localparam int CFG_IDX_W   = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 2'd2;

  localparam logic [CFG_DIM_W-1:0] COLUMNS_RESET = 11'd65;
  localparam logic [CFG_DIM_W-1:0] ROWS_RESET    = 11'd49;
  localparam logic [SP_W-1:0]      SPACING_RESET = 6'd10;

  typedef enum logic [2:0] {P_TOP, P_RIGHT, P_BOTTOM, P_LEFT, P_NONE} point_t;

  // Line store access for one cycle.
  typedef struct packed {
    logic             re;
    logic [COL_W-1:0] raddr;
    logic             we;
    logic [COL_W-1:0] waddr;
    logic             wdata;
  } mem_req_t;

  // A completed cell that yields at least one segment.
  typedef struct packed {
    logic [CASE_W-1:0]  code;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [SP_W-1:0]    spacing;
  } cell_t;

  function automatic logic [1:0] seg_count(logic [CASE_W-1:0] code);
    logic [1:0] n;
    case (code) inside
      4'd0, 4'd15: n = 2'd0;
      4'd5, 4'd10: n = 2'd2;
      default:     n = 2'd1;
    endcase
    return n;
  endfunction

  // Endpoint idx of the case: idx[1] picks the segment, idx[0] the end.
  function automatic point_t seg_end(logic [CASE_W-1:0] code, logic [1:0] idx);
    point_t e [4];
    case (code)
      4'd1:    e = '{P_BOTTOM, P_LEFT,   P_NONE,  P_NONE};
      4'd2:    e = '{P_BOTTOM, P_RIGHT,  P_NONE,  P_NONE};
      4'd3:    e = '{P_LEFT,   P_RIGHT,  P_NONE,  P_NONE};
      4'd4:    e = '{P_TOP,    P_RIGHT,  P_NONE,  P_NONE};
      4'd5:    e = '{P_TOP,    P_RIGHT,  P_LEFT,  P_BOTTOM};
      4'd6:    e = '{P_TOP,    P_BOTTOM, P_NONE,  P_NONE};
      4'd7:    e = '{P_TOP,    P_LEFT,   P_NONE,  P_NONE};
      4'd8:    e = '{P_TOP,    P_LEFT,   P_NONE,  P_NONE};
      4'd9:    e = '{P_TOP,    P_BOTTOM, P_NONE,  P_NONE};
      4'd10:   e = '{P_TOP,    P_LEFT,   P_RIGHT, P_BOTTOM};
      4'd11:   e = '{P_TOP,    P_RIGHT,  P_NONE,  P_NONE};
      4'd12:   e = '{P_LEFT,   P_RIGHT,  P_NONE,  P_NONE};
      4'd13:   e = '{P_RIGHT,  P_BOTTOM, P_NONE,  P_NONE};
      4'd14:   e = '{P_LEFT,   P_BOTTOM, P_NONE,  P_NONE};
      default: e = '{P_NONE,   P_NONE,   P_NONE,  P_NONE};
    endcase
    return e[idx];
  endfunction

  function automatic logic [COORD_W-1:0] pt_x(point_t p, logic [COORD_W-1:0] cx,
                                               logic [SP_W-1:0] s);
    logic [COORD_W-1:0] s_ext;
    logic [COORD_W-1:0] h_ext;
    logic [COORD_W-1:0] r;
    s_ext = COORD_W'(s);
    h_ext = COORD_W'(s >> 1);
    case (p)
      P_TOP, P_BOTTOM: r = cx + h_ext;
      P_RIGHT:         r = cx + s_ext;
      default:         r = cx;
    endcase
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] pt_y(point_t p, logic [COORD_W-1:0] cy,
                                               logic [SP_W-1:0] s);
    logic [COORD_W-1:0] s_ext;
    logic [COORD_W-1:0] h_ext;
    logic [COORD_W-1:0] r;
    s_ext = COORD_W'(s);
    h_ext = COORD_W'(s >> 1);
    case (p)
      P_RIGHT, P_LEFT: r = cy + h_ext;
      P_BOTTOM:        r = cy + s_ext;
      default:         r = cy;
    endcase
    return r;
  endfunction

endpackage

// ===== src/msq_row_mem.sv =====
// One-bit line store of the previous row: one write and one registered read per cycle.
// Depends on msq_pkg for the depth and the request struct.
module msq_row_mem (
  input  logic              clk,
  input  msq_pkg::mem_req_t req,
  output logic              rdata
);
  import msq_pkg::*;

  logic mem [MAX_COLUMNS];

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== src/msq_scan.sv =====
// Raster position tracking, line store read-modify-write and corner code assembly.
// Depends on msq_pkg; drives msq_row_mem and hands completed cells to msq_emit.
module msq_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          sample_bit,
  input  logic                          frame_start,
  input  logic [msq_pkg::LIM_W-1:0]     cols,
  input  logic [msq_pkg::CFG_DIM_W-1:0] rows,
  input  logic [msq_pkg::SP_W-1:0]      spacing,
  output msq_pkg::mem_req_t             mem_req,
  input  logic                          mem_rdata,
  output msq_pkg::cell_t                cell_info,
  output logic                          cell_valid,
  input  logic                          cell_ready
);
  import msq_pkg::*;

  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic             left;

  logic             s1_valid;
  logic [COL_W-1:0] s1_x;
  logic [ROW_W-1:0] s1_y;
  logic             s1_bit;
  logic             s1_left;
  logic             fwd_hit;
  logic             fwd_bit;
  logic             tl;

  logic             accept;
  logic             s1_adv;
  logic [COL_W-1:0] x_in;
  logic [ROW_W-1:0] y_in;
  logic             last_col;
  logic             last_row;
  logic             tr;
  logic [CASE_W-1:0] code;
  logic             emit;
  logic [COL_W-1:0] xm1;
  logic [ROW_W-1:0] ym1;
  logic [COL_W+SP_W-1:0] cx_full;
  logic [ROW_W+SP_W-1:0] cy_full;

  assign x_in     = frame_start ? '0 : col_cnt;
  assign y_in     = frame_start ? '0 : row_cnt;
  assign last_col = (LIM_W'(x_in) + LIM_W'(1)) >= cols;
  assign last_row = (CFG_DIM_W'(y_in) + CFG_DIM_W'(1)) >= rows;

  // Store entry x holds the previous row until this sample rewrites it; the
  // top-left corner is the previous sample's top-right.
  assign tr    = fwd_hit ? fwd_bit : mem_rdata;
  assign code  = {tl, tr, s1_bit, s1_left};
  assign emit  = (s1_x != '0) && (s1_y != '0) && (seg_count(code) != 2'd0);

  assign s1_adv   = s1_valid && (!emit || cell_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  assign xm1     = s1_x - COL_W'(1);
  assign ym1     = s1_y - ROW_W'(1);
  assign cx_full = {SP_W'(0), xm1} * {COL_W'(0), spacing};
  assign cy_full = {SP_W'(0), ym1} * {ROW_W'(0), spacing};

  assign cell_valid        = s1_valid && emit;
  assign cell_info.code    = code;
  assign cell_info.cx      = COORD_W'(cx_full);
  assign cell_info.cy      = COORD_W'(cy_full);
  assign cell_info.spacing = spacing;

  assign mem_req.re    = accept;
  assign mem_req.raddr = x_in;
  assign mem_req.we    = s1_adv;
  assign mem_req.waddr = s1_x;
  assign mem_req.wdata = s1_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      left     <= 1'b0;
      s1_valid <= 1'b0;
      tl       <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (accept) begin
        left     <= sample_bit;
        s1_valid <= 1'b1;
        if (last_col) begin
          col_cnt <= '0;
          row_cnt <= last_row ? '0 : y_in + ROW_W'(1);
        end else begin
          col_cnt <= x_in + COL_W'(1);
          row_cnt <= y_in;
        end
        // Entry being written back this cycle is read stale by the new sample.
        fwd_hit <= s1_adv && (s1_x == x_in);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        tl <= tr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x    <= x_in;
      s1_y    <= y_in;
      s1_bit  <= sample_bit;
      s1_left <= left;
      fwd_bit <= s1_bit;
    end
  end

endmodule

// ===== src/msq_emit.sv =====
// Segment emitter: holds one cell and issues its one or two segments through
// the output register. Depends on msq_pkg for the table and coordinate functions.
module msq_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  msq_pkg::cell_t              cell_info,
  input  logic                        cell_valid,
  output logic                        cell_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [msq_pkg::COORD_W-1:0] seg_x0,
  output logic [msq_pkg::COORD_W-1:0] seg_y0,
  output logic [msq_pkg::COORD_W-1:0] seg_x1,
  output logic [msq_pkg::COORD_W-1:0] seg_y1,
  output logic [msq_pkg::CASE_W-1:0]  cell_case,
  output logic                        last_segment
);
  import msq_pkg::*;

  logic   s2_valid;
  cell_t  s2;
  logic   k;

  logic   last_k;
  logic   out_load;
  logic   s2_done;
  point_t p0;
  point_t p1;

  assign last_k     = k || (seg_count(s2.code) != 2'd2);
  assign out_load   = s2_valid && (!out_valid || out_ready);
  assign s2_done    = out_load && last_k;
  assign cell_ready = !s2_valid || s2_done;
  assign p0         = seg_end(s2.code, {k, 1'b0});
  assign p1         = seg_end(s2.code, {k, 1'b1});

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      k         <= 1'b0;
    end else begin
      if (cell_valid && cell_ready) begin
        s2_valid <= 1'b1;
        k        <= 1'b0;
      end else if (s2_done) begin
        s2_valid <= 1'b0;
      end else if (out_load) begin
        k <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cell_valid && cell_ready) begin
      s2 <= cell_info;
    end
    if (out_load) begin
      seg_x0       <= pt_x(p0, s2.cx, s2.spacing);
      seg_y0       <= pt_y(p0, s2.cy, s2.spacing);
      seg_x1       <= pt_x(p1, s2.cx, s2.spacing);
      seg_y1       <= pt_y(p1, s2.cy, s2.spacing);
      cell_case    <= s2.code;
      last_segment <= last_k;
    end
  end

endmodule

// ===== src/marching_squares_segments.sv =====
// Binary-grid marching squares: samples in raster order in, isoline segments
// out in pixel coordinates. Each accepted sample at column >= 1 and row >= 1
// closes one cell and yields zero, one or two segments; the last one carries
// last_segment. The block takes one sample per cycle while cells yield at most
// one segment and the output is taken every cycle; a saddle cell (two diagonal
// corners set, the other two clear) issues both of its segments in turn through
// the single output register. At a sample's transfer the line store is read and
// the sample's corner bits and position are registered in msq_scan; the cell is
// then captured in the msq_emit holding register, and the output register is
// loaded from it. The previous row lives in a one-bit, MAX_COLUMNS-deep line
// store with one read and one write port; it needs no clearing pass, since each
// row is written before it is read back.
// Depends on msq_pkg, msq_row_mem, msq_scan and msq_emit.
module marching_squares_segments (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [msq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msq_pkg::CFG_DIM_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              sample_bit,
  input  logic                              frame_start,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [msq_pkg::COORD_W-1:0]       seg_x0,
  output logic [msq_pkg::COORD_W-1:0]       seg_y0,
  output logic [msq_pkg::COORD_W-1:0]       seg_x1,
  output logic [msq_pkg::COORD_W-1:0]       seg_y1,
  output logic [msq_pkg::CASE_W-1:0]        cell_case,
  output logic                              last_segment
);
  import msq_pkg::*;

  logic [CFG_DIM_W-1:0] grid_columns;
  logic [CFG_DIM_W-1:0] grid_rows;
  logic [SP_W-1:0]      cell_spacing;

  logic [LIM_W-1:0]     cols;
  logic [CFG_DIM_W-1:0] rows;
  mem_req_t             mem_req;
  logic                 mem_rdata;
  cell_t                cell_info;
  logic                 cell_valid;
  logic                 cell_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= COLUMNS_RESET;
      grid_rows    <= ROWS_RESET;
      cell_spacing <= SPACING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMNS: grid_columns <= cfg_data;
        CFG_ROWS:    grid_rows    <= cfg_data;
        CFG_SPACING: cell_spacing <= cfg_data[SP_W-1:0];
        default:     ;
      endcase
    end
  end

  // Clamp grid size to what the counters and line store support.
  always_comb begin
    if (grid_columns < CFG_DIM_W'(2)) begin
      cols = LIM_W'(2);
    end else if (LIM_W'(grid_columns) > LIM_W'(MAX_COLUMNS)) begin
      cols = LIM_W'(MAX_COLUMNS);
    end else begin
      cols = LIM_W'(grid_columns);
    end
    if (grid_rows < CFG_DIM_W'(2)) begin
      rows = CFG_DIM_W'(2);
    end else if (grid_rows > CFG_DIM_W'(MAX_ROWS)) begin
      rows = CFG_DIM_W'(MAX_ROWS);
    end else begin
      rows = grid_rows;
    end
  end

  msq_row_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  msq_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_bit  (sample_bit),
    .frame_start (frame_start),
    .cols        (cols),
    .rows        (rows),
    .spacing     (cell_spacing),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .cell_info   (cell_info),
    .cell_valid  (cell_valid),
    .cell_ready  (cell_ready)
  );

  msq_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .cell_info    (cell_info),
    .cell_valid   (cell_valid),
    .cell_ready   (cell_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .seg_x0       (seg_x0),
    .seg_y0       (seg_y0),
    .seg_x1       (seg_x1),
    .seg_y1       (seg_y1),
    .cell_case    (cell_case),
    .last_segment (last_segment)
  );

endmodule

// ===== src/msq_check.sv =====
// Port-level checks on the segment output of marching_squares_segments.
// Depends on msq_pkg; attached to the top level by the bind below.
module msq_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [msq_pkg::COORD_W-1:0] seg_x0,
  input logic [msq_pkg::COORD_W-1:0] seg_y0,
  input logic [msq_pkg::COORD_W-1:0] seg_x1,
  input logic [msq_pkg::COORD_W-1:0] seg_y1,
  input logic [msq_pkg::CASE_W-1:0]  cell_case,
  input logic                        last_segment
);
  import msq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(seg_x0) && $stable(seg_y0)
      && $stable(seg_x1) && $stable(seg_y1) && $stable(cell_case)
      && $stable(last_segment))
    else $error("segment changed while stalled");

  a_no_empty_case: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cell_case != 4'd0 && cell_case != 4'd15)
    else $error("segment from an empty or full cell");

  a_first_of_two: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_segment |-> cell_case == 4'd5 || cell_case == 4'd10)
    else $error("non-final segment outside a saddle case");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_segment |=> out_valid && last_segment
      && $stable(cell_case))
    else $error("second saddle segment did not follow at once");

endmodule

bind marching_squares_segments msq_check u_msq_check (.*);
